[hdl/masked_byte_pattern_scanner_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern scanner
// Shared property wrappers, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH
`define MASKED_BYTE_PATTERN_SCANNER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define MBPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scanner check failed");

// next-cycle implication
`define MBPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scanner check failed");

`else

`define MBPS_ASSERT_NOW(label, ante, cons)
`define MBPS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbps_pkg;

    localparam int ADDR_W     = 48;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CARE_W     = 16;
    localparam int LEN_CFG_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_CARE_MASK    = 3'd2,
        REG_PATTERN_LEN  = 3'd3,
        REG_BASE_ADDRESS = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] pattern_low;
        logic [CFG_DATA_W-1:0] pattern_high;
        logic [CARE_W-1:0]     care_mask;
        logic [LEN_CFG_W-1:0]  pattern_length;
        logic [ADDR_W-1:0]     base_address;
    } cfg_t;

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              gate;
        logic [ADDR_W-1:0] start;
    } stage_t;

    function automatic logic [BYTE_W-1:0] pattern_byte(cfg_t c, int unsigned i);
        logic [BYTE_W-1:0] b;
        b = '0;
        if (i < 8) begin
            b = c.pattern_low[{i[2:0], 3'b000} +: BYTE_W];
        end else if (i < 16) begin
            b = c.pattern_high[{i[2:0], 3'b000} +: BYTE_W];
        end
        return b;
    endfunction

    function automatic logic care_bit(cfg_t c, int unsigned i);
        logic r;
        r = 1'b0;
        if (i < CARE_W) begin
            r = c.care_mask[i[3:0]];
        end
        return r;
    endfunction

endpackage

[hdl/masked_byte_pattern_scanner.sv]
// Path: window stage register, then masked compare into the output register.
// Throughput: one byte per cycle; the window register and the output
// register each hold one request, and ready falls only while the output stalls.
// Reset (aresetn low, synchronous): empties both stages, clears the offset
// and loads the register defaults (care mask all ones, pattern length one).
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner
// Wildcard byte signature scan over a streamed memory image.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "masked_byte_pattern_scanner_macros.svh"

module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mbps_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mbps_pkg::ADDR_W-1:0]       m_tdata,   // [47:0] match_address
    output logic                              m_tuser,   // [0] match_valid
    output logic                              m_tlast
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    mbps_pkg::cfg_t              cfg;
    mbps_pkg::stage_t            stage;
    logic [LEN_W-1:0]            len_eff;
    logic [mbps_pkg::BYTE_W-1:0] window [MAX_PATTERN];
    logic                        advance;
    logic                        accept;

    assign len_eff = (32'(cfg.pattern_length) > 32'(MAX_PATTERN)) ?
                     LEN_W'(MAX_PATTERN) : LEN_W'(cfg.pattern_length);

    assign s_tready = !stage.valid || advance;
    assign accept   = s_tvalid && s_tready;

    mbps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mbps_window #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .advance   (advance),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .len_eff   (len_eff),
        .window    (window),
        .stage     (stage)
    );

    mbps_match #(
        .MAX_PATTERN (MAX_PATTERN),
        .LEN_W       (LEN_W)
    ) u_match (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .len_eff  (len_eff),
        .window   (window),
        .stage    (stage),
        .advance  (advance),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `MBPS_ASSERT_NOW(a_result_has_cause, m_tvalid, m_tuser || m_tlast)
    `MBPS_ASSERT_NOW(a_miss_addr_zero, m_tvalid && !m_tuser, m_tdata == '0)
    `MBPS_ASSERT_NOW(a_stall_only_on_output, !s_tready, m_tvalid && !m_tready)

endmodule

[hdl/mbps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration register file: pattern, care mask, length and base address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mbps_pkg::cfg_t                    cfg
);

    mbps_pkg::cfg_t cfg_reg;
    mbps_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (mbps_pkg::cfg_reg_t'(cfg_index))
                mbps_pkg::REG_PATTERN_LOW: begin
                    cfg_next.pattern_low = cfg_data;
                end
                mbps_pkg::REG_PATTERN_HIGH: begin
                    cfg_next.pattern_high = cfg_data;
                end
                mbps_pkg::REG_CARE_MASK: begin
                    cfg_next.care_mask = cfg_data[mbps_pkg::CARE_W-1:0];
                end
                mbps_pkg::REG_PATTERN_LEN: begin
                    cfg_next.pattern_length = cfg_data[mbps_pkg::LEN_CFG_W-1:0];
                end
                mbps_pkg::REG_BASE_ADDRESS: begin
                    cfg_next.base_address = cfg_data[mbps_pkg::ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pattern_low    <= '0;
            cfg_reg.pattern_high   <= '0;
            cfg_reg.care_mask      <= '1;
            cfg_reg.pattern_length <= mbps_pkg::LEN_CFG_W'(1);
            cfg_reg.base_address   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hdl/mbps_window.sv]
// ----------------------------------------------------------------------------
// mbps_window
// Input stage: shift register of recent bytes, image offset and match gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_window #(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           accept,
    input  logic                           advance,
    input  logic [mbps_pkg::BYTE_W-1:0]    data_byte,
    input  logic                           last_byte,
    input  logic [LEN_W-1:0]               len_eff,
    output logic [mbps_pkg::BYTE_W-1:0]    window [MAX_PATTERN],
    output mbps_pkg::stage_t               stage
);

    localparam logic [mbps_pkg::ADDR_W-1:0] OFFSET_MAX = '1;

    logic [mbps_pkg::BYTE_W-1:0] window_reg [MAX_PATTERN];
    logic [mbps_pkg::ADDR_W-1:0] offset_reg;
    logic [mbps_pkg::ADDR_W-1:0] offset_next;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        last_reg;
    logic                        gate_reg;
    logic [mbps_pkg::ADDR_W-1:0] start_reg;
    logic [mbps_pkg::ADDR_W-1:0] len_m1;
    logic                        gate_next;

    assign window = window_reg;

    assign len_m1    = mbps_pkg::ADDR_W'(len_eff) - mbps_pkg::ADDR_W'(1);
    assign gate_next = (len_eff != '0) && (offset_reg >= len_m1);

    always_comb begin
        offset_next = offset_reg;
        if (last_byte) begin
            offset_next = '0;
        end else if (offset_reg != OFFSET_MAX) begin
            offset_next = offset_reg + mbps_pkg::ADDR_W'(1);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
            valid_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                offset_reg <= offset_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg[0] <= data_byte;
            for (int i = 1; i < MAX_PATTERN; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
            last_reg  <= last_byte;
            gate_reg  <= gate_next;
            start_reg <= offset_reg - len_m1;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.last  = last_reg;
    assign stage.gate  = gate_reg;
    assign stage.start = start_reg;

endmodule

[hdl/mbps_match.sv]
// ----------------------------------------------------------------------------
// mbps_match
// Result stage: masked window compare, address sum and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbps_match #(
    parameter int MAX_PATTERN = 16,
    parameter int LEN_W       = 5
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mbps_pkg::cfg_t                 cfg,
    input  logic [LEN_W-1:0]               len_eff,
    input  logic [mbps_pkg::BYTE_W-1:0]    window [MAX_PATTERN],
    input  mbps_pkg::stage_t               stage,
    output logic                           advance,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [mbps_pkg::ADDR_W-1:0]    m_tdata,
    output logic                           m_tuser,
    output logic                           m_tlast
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic                        hit;
    logic [mbps_pkg::ADDR_W-1:0] addr;
    logic                        valid_reg;
    logic                        valid_next;
    logic                        hit_reg;
    logic                        last_reg;
    logic [mbps_pkg::ADDR_W-1:0] addr_reg;

    always_comb begin
        int j;
        j   = 0;
        hit = stage.gate;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < int'(len_eff)) begin
                j = int'(len_eff) - 1 - i;
                if (mbps_pkg::care_bit(cfg, i) &&
                    window[IDX_W'(j)] != mbps_pkg::pattern_byte(cfg, i)) begin
                    hit = 1'b0;
                end
            end
        end
    end

    assign addr    = hit ? (cfg.base_address + stage.start) : '0;
    assign advance = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = stage.valid && (hit || stage.last);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg  <= hit;
            last_reg <= stage.last;
            addr_reg <= addr;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = hit_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = addr_reg;

endmodule

[tb/tb_masked_byte_pattern_scanner.sv]
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scanner
// Streams byte images through the scanner under a series of pattern, care
// mask, length and base settings, predicts every match and scan-end report
// in a tracker object, and compares each report field by field. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_masked_byte_pattern_scanner;

    localparam int WIN_DEPTH    = 16;
    localparam int SETTLE_TICKS = 8;
    localparam int RANDOM_BYTES = 1500;

    typedef struct packed {
        logic                        hit;
        logic [mbps_pkg::ADDR_W-1:0] addr;
        logic                        done;
    } scan_report_t;

    class scan_tracker;
        logic [mbps_pkg::CFG_DATA_W-1:0] pat_lo;
        logic [mbps_pkg::CFG_DATA_W-1:0] pat_hi;
        logic [mbps_pkg::CARE_W-1:0]     care;
        logic [mbps_pkg::LEN_CFG_W-1:0]  plen;
        logic [mbps_pkg::ADDR_W-1:0]     base;
        logic [mbps_pkg::BYTE_W-1:0]     window [WIN_DEPTH];
        logic [mbps_pkg::ADDR_W-1:0]     offset;
        scan_report_t                    pending_reports [$];
        int                              mismatches;

        function new();
            pat_lo = '0;
            pat_hi = '0;
            care   = '1;
            plen   = 5'd1;
            base   = '0;
            offset = '0;
            foreach (window[i]) window[i] = '0;
            mismatches = 0;
        endfunction

        function logic [mbps_pkg::BYTE_W-1:0] pattern_byte_at(int unsigned i);
            if (i < 8) return pat_lo[8*i +: 8];
            if (i < 16) return pat_hi[8*(i-8) +: 8];
            return '0;
        endfunction

        function void load_reg(mbps_pkg::cfg_reg_t idx,
                               logic [mbps_pkg::CFG_DATA_W-1:0] v);
            case (idx)
                mbps_pkg::REG_PATTERN_LOW:  pat_lo = v;
                mbps_pkg::REG_PATTERN_HIGH: pat_hi = v;
                mbps_pkg::REG_CARE_MASK:    care   = v[mbps_pkg::CARE_W-1:0];
                mbps_pkg::REG_PATTERN_LEN:  plen   = v[mbps_pkg::LEN_CFG_W-1:0];
                mbps_pkg::REG_BASE_ADDRESS: base   = v[mbps_pkg::ADDR_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_byte(logic [mbps_pkg::BYTE_W-1:0] b, logic last);
            int unsigned  len;
            logic         hit;
            scan_report_t r;
            len = plen;
            if (len > WIN_DEPTH) len = WIN_DEPTH;
            for (int i = WIN_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = b;
            hit    = 1'b0;
            r.addr = '0;
            if (len > 0 && offset >= mbps_pkg::ADDR_W'(len - 1)) begin
                hit = 1'b1;
                for (int unsigned i = 0; i < len; i++) begin
                    if (i < mbps_pkg::CARE_W && care[i] &&
                        window[len-1-i] != pattern_byte_at(i))
                        hit = 1'b0;
                end
                if (hit) r.addr = base + offset - mbps_pkg::ADDR_W'(len - 1);
            end
            if (last) offset = '0;
            else if (offset != '1) offset = offset + 1'b1;
            r.hit  = hit;
            r.done = last;
            if (hit || last) pending_reports.insert(pending_reports.size(), r);
        endfunction

        function void check_report(logic hit, logic [mbps_pkg::ADDR_W-1:0] addr,
                                   logic done);
            scan_report_t e;
            if (pending_reports.size() == 0) begin
                $display("%0t: expected no report, actual match_valid=%0b match_address=%h scan_done=%0b",
                         $time, hit, addr, done);
                mismatches++;
                return;
            end
            e = pending_reports.pop_front();
            if (hit !== e.hit) begin
                $display("%0t: match_valid expected %0b actual %0b", $time, e.hit, hit);
                mismatches++;
            end
            if (addr !== e.addr) begin
                $display("%0t: match_address expected %h actual %h", $time, e.addr, addr);
                mismatches++;
            end
            if (done !== e.done) begin
                $display("%0t: scan_done expected %0b actual %0b", $time, e.done, done);
                mismatches++;
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mbps_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [mbps_pkg::BYTE_W-1:0]     s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [mbps_pkg::ADDR_W-1:0]     m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    scan_tracker tracker;
    bit          tx_calm;
    bit          rx_calm;
    int          stall_left;

    masked_byte_pattern_scanner dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(negedge aclk) begin
        if (stall_left == 0 && !rx_calm && $urandom_range(0, 5) == 0)
            stall_left = pick_pause();
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_report(m_tuser, m_tdata, m_tlast);
    end

    task automatic write_reg(mbps_pkg::cfg_reg_t idx, logic [mbps_pkg::CFG_DATA_W-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        tracker.load_reg(idx, v);
        @(negedge aclk);
    endtask

    task automatic set_config(logic [mbps_pkg::CFG_DATA_W-1:0] pl,
                              logic [mbps_pkg::CFG_DATA_W-1:0] ph,
                              logic [mbps_pkg::CARE_W-1:0] care,
                              logic [mbps_pkg::LEN_CFG_W-1:0] plen,
                              logic [mbps_pkg::ADDR_W-1:0] base);
        write_reg(mbps_pkg::REG_PATTERN_LOW, pl);
        write_reg(mbps_pkg::REG_PATTERN_HIGH, ph);
        write_reg(mbps_pkg::REG_CARE_MASK, mbps_pkg::CFG_DATA_W'(care));
        write_reg(mbps_pkg::REG_PATTERN_LEN, mbps_pkg::CFG_DATA_W'(plen));
        write_reg(mbps_pkg::REG_BASE_ADDRESS, mbps_pkg::CFG_DATA_W'(base));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_byte(logic [mbps_pkg::BYTE_W-1:0] b, logic last);
        int gap;
        gap = 0;
        if (!tx_calm && $urandom_range(0, 3) == 0) gap = pick_pause();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(b, last);
        @(negedge aclk);
    endtask

    // drop valid, drain outstanding reports, then let the pipeline empty
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending_reports.size() != 0) @(negedge aclk);
        repeat (SETTLE_TICKS) @(negedge aclk);
    endtask

    initial begin
        int                              sent;
        int                              n;
        int                              eff;
        int                              embed;
        int                              r;
        logic [mbps_pkg::CFG_DATA_W-1:0] pl;
        logic [mbps_pkg::CFG_DATA_W-1:0] ph;
        logic [mbps_pkg::CARE_W-1:0]     care;
        logic [mbps_pkg::LEN_CFG_W-1:0]  plen;
        logic [mbps_pkg::ADDR_W-1:0]     base;
        logic [mbps_pkg::BYTE_W-1:0]     b;
        logic                            last;

        tracker    = new();
        aresetn    = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = mbps_pkg::REG_PATTERN_LOW;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        stall_left = 0;
        tx_calm    = 1'b1;
        rx_calm    = 1'b1;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // defaults after reset: single byte 0x00, all positions cared for
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h5A, 1'b1);
        wait_idle();

        // full-length pattern, base at the top so the address wraps to zero
        set_config('1, '0, '1, 5'd16, '1);
        send_byte(8'h77, 1'b0);
        for (int k = 0; k < 16; k++)
            send_byte(k < 8 ? 8'hFF : 8'h00, k == 15);
        wait_idle();

        // zero length never matches
        write_reg(mbps_pkg::REG_PATTERN_LEN, '0);
        cfg_valid <= 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_idle();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            pl = {$urandom, $urandom};
            ph = {$urandom, $urandom};
            if ($urandom_range(0, 4) == 0) begin
                b  = mbps_pkg::BYTE_W'($urandom);
                pl = {8{b}};
                ph = {8{b}};
            end
            case ($urandom_range(0, 5))
                0:       care = '1;
                1:       care = '0;
                default: care = mbps_pkg::CARE_W'($urandom);
            endcase
            r = $urandom_range(0, 9);
            if (r == 0) plen = '0;
            else if (r == 1) plen = mbps_pkg::LEN_CFG_W'($urandom_range(17, 31));
            else if (r == 2) plen = 5'd16;
            else plen = mbps_pkg::LEN_CFG_W'($urandom_range(1, 16));
            case ($urandom_range(0, 3))
                0:       base = '0;
                1:       base = '1;
                2:       base = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 200);
                default: base = {16'($urandom), $urandom};
            endcase
            set_config(pl, ph, care, plen, base);
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);

            eff   = (plen > WIN_DEPTH) ? WIN_DEPTH : plen;
            embed = -1;
            n     = $urandom_range(60, 180);
            for (int k = 0; k < n; k++) begin
                if (embed < 0 && eff > 0 && $urandom_range(0, 3) == 0) embed = 0;
                if (embed >= 0) begin
                    if ($urandom_range(0, 24) == 0 || !care[embed])
                        b = mbps_pkg::BYTE_W'($urandom);
                    else b = tracker.pattern_byte_at(embed);
                    embed++;
                    if (embed >= eff) embed = -1;
                end else if ($urandom_range(0, 2) == 0) begin
                    b = tracker.pattern_byte_at($urandom_range(0, 15));
                end else begin
                    b = mbps_pkg::BYTE_W'($urandom);
                end
                last = ($urandom_range(0, 39) == 0);
                send_byte(b, last);
            end
            sent += n;
            wait_idle();
        end

        if (tracker.mismatches == 0 && tracker.pending_reports.size() == 0) begin
            $display("** masked_byte_pattern_scanner: PASSED **");
        end else begin
            $display("** masked_byte_pattern_scanner: FAILED **");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("** masked_byte_pattern_scanner: FAILED **");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/mbps_pkg.sv
hdl/mbps_cfg_regs.sv
hdl/mbps_window.sv
hdl/mbps_match.sv
hdl/masked_byte_pattern_scanner.sv
tb/tb_masked_byte_pattern_scanner.sv
